// ----- hdl/ball_euler_motion_step_assert.svh -----
// Assertion macros used by the checker file of the ball motion step block.
`ifndef BALL_EULER_MOTION_STEP_ASSERT_SVH
`define BALL_EULER_MOTION_STEP_ASSERT_SVH

// Concurrent assertion sampled on clk and switched off while arst_n is low.
`define BEMS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Concurrent assertion sampled on clk that also holds during reset.
`define BEMS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/bems_pkg.sv -----
// Types and constants of the ball motion step block.
`timescale 1ns / 1ps

package bems_pkg;

	localparam int unsigned QW   = 24;
	localparam int unsigned FW   = 16;
	localparam int unsigned TOLW = 23;
	localparam int unsigned RADW = 8;

	typedef logic signed [QW-1:0] q_t;

	// Request modes.
	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_FORCE = 2'd1;
	localparam logic [1:0] MODE_SINK  = 2'd2;
	localparam logic [1:0] MODE_PLACE = 2'd3;

	// Sink status codes.
	localparam logic [1:0] ST_TABLE   = 2'd0;
	localparam logic [1:0] ST_SINKING = 2'd1;
	localparam logic [1:0] ST_SUNK    = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_TIME_STEP = 2'd0;
	localparam logic [1:0] REG_DRAG      = 2'd1;
	localparam logic [1:0] REG_TOLERANCE = 2'd2;

	localparam logic [FW-1:0]   TIME_STEP_RST = 16'd1092;
	localparam logic [FW-1:0]   DRAG_RST      = 16'd64881;
	localparam logic [TOLW-1:0] TOLERANCE_RST = 23'd26;

	localparam q_t Q_ONE  = 24'sd256;
	localparam q_t Q_FIVE = 24'sd1280;

	typedef struct packed {
		logic [1:0]      mode;
		q_t              value_x;
		q_t              value_y;
		logic [RADW-1:0] radius_in;
	} in_item_t;

	typedef struct packed {
		q_t              position_x;
		q_t              position_y;
		q_t              velocity_x;
		q_t              velocity_y;
		logic [RADW-1:0] radius_out;
		logic [1:0]      sink_status;
	} out_item_t;

	typedef struct packed {
		logic [1:0]      index;
		logic [TOLW-1:0] value;
	} cfg_req_t;

	// Clamp a 25-bit signed sum to the Q16.8 range.
	function automatic q_t sat25(input logic signed [QW:0] v);
		if (v[QW] != v[QW-1]) begin
			return v[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
		end
		return v[QW-1:0];
	endfunction

	// Magnitude of a Q16.8 value; the most negative value maps to 2^23.
	function automatic logic [QW-1:0] mag(input q_t v);
		return v[QW-1] ? (~v + QW'(1)) : v;
	endfunction

endpackage

// ----- hdl/bems_if.sv -----
// Request, result and configuration channels of the ball motion step block.
`timescale 1ns / 1ps

interface bems_item_if;
	import bems_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bems_result_if;
	import bems_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bems_cfg_if;
	import bems_pkg::*;
	logic     valid;
	logic     ready;
	cfg_req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/ball_euler_motion_step.sv -----
// Top level of the single-ball Euler motion step with drag and sinking.
`timescale 1ns / 1ps

// The block holds one ball in signed Q16.8 and takes one request at a time on
// the item channel: place the ball, add a force, start sinking toward a hole,
// or advance one tick. Every request returns one result on the result channel,
// the ball state after it. The tick arithmetic runs through one shared 24 x 16 bit
// multiplier, followed by a register, and one saturating adder under a small
// step sequencer; force requests use their own saturating adds. A tick on
// the table runs six products through the multiplier, overlapped with their
// write-backs, a sinking tick runs two, and every other request goes straight
// from idle to the done state. The item channel is ready only while the
// sequencer is idle. The finished result sits in an output register, so the
// next request is taken while it still waits; a result is held back only when
// the one before it has not been taken. Configuration writes are always
// accepted and should only be issued while no request is in flight; a write
// to an index past the velocity tolerance register is ignored.

module ball_euler_motion_step (
	input logic            clk,
	input logic            arst_n,
	bems_item_if.sink      item,
	bems_result_if.source  result,
	bems_cfg_if.sink       cfg
);
	import bems_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_TABLE,
		S_SINK,
		S_DONE
	} state_t;

	localparam logic [2:0] TABLE_LAST = 3'd6;
	localparam logic [2:0] SINK_LAST  = 3'd3;

	state_t          state_q;
	logic [2:0]      step_q;

	logic [FW-1:0]   time_step_q;
	logic [FW-1:0]   drag_q;
	logic [TOLW-1:0] tolerance_q;

	q_t              pos_x_q, pos_y_q;
	q_t              vel_x_q, vel_y_q;
	q_t              force_x_q, force_y_q;
	q_t              hole_x_q, hole_y_q;
	logic [RADW-1:0] radius_q;
	logic [1:0]      status_q;

	logic            res_valid_q;
	out_item_t       res_q;
	logic            load_res;

	// Shared multiplier and its pipeline register.
	q_t                  mul_a;
	logic [FW-1:0]       mul_f;
	logic signed [40:0]  prod_d;
	logic signed [40:0]  prod_q;
	logic signed [40:0]  rnd_wide;
	logic signed [QW:0]  rnd_25;
	q_t                  rnd;

	// Shared saturating adder.
	q_t                  add_a;
	q_t                  add_b;
	logic                add_sub;
	logic signed [QW:0]  sum_25;
	q_t                  sum;
	logic                below_tol;

	// Plain saturating adds for the force accumulator.
	q_t                  force_x_next, force_y_next;

	assign prod_d   = 41'(mul_a) * 41'($signed({1'b0, mul_f}));
	// Round half up, then floor the division by 2^16 with an arithmetic shift.
	assign rnd_wide = prod_q + 41'sd32768;
	assign rnd_25   = rnd_wide[40:16];
	assign rnd      = sat25(rnd_25);

	assign sum_25    = add_sub ? ({add_a[QW-1], add_a} - {add_b[QW-1], add_b})
	                           : ({add_a[QW-1], add_a} + {add_b[QW-1], add_b});
	assign sum       = sat25(sum_25);
	assign below_tol = mag(sum) < {1'b0, tolerance_q};

	assign force_x_next = sat25({force_x_q[QW-1], force_x_q}
	                            + {item.data.value_x[QW-1], item.data.value_x});
	assign force_y_next = sat25({force_y_q[QW-1], force_y_q}
	                            + {item.data.value_y[QW-1], item.data.value_y});

	// Step schedule. On the table each step writes back the product issued in
	// the step before, so a velocity is already updated when the position
	// step reads it. A sinking tick first forms the velocity toward the hole.
	always_comb begin
		mul_a   = force_x_q;
		mul_f   = time_step_q;
		add_a   = vel_x_q;
		add_b   = rnd;
		add_sub = 1'b0;
		case (state_q)
			S_TABLE: begin
				case (step_q)
					3'd0: begin
						mul_a = force_x_q;
					end
					3'd1: begin
						add_a = vel_x_q;
						mul_a = force_y_q;
					end
					3'd2: begin
						add_a = vel_y_q;
						mul_a = vel_x_q;
					end
					3'd3: begin
						add_a = pos_x_q;
						mul_a = vel_y_q;
					end
					3'd4: begin
						add_a = pos_y_q;
						mul_a = vel_x_q;
						mul_f = drag_q;
					end
					3'd5: begin
						add_a = '0;
						mul_a = vel_y_q;
						mul_f = drag_q;
					end
					default: begin
						add_a = '0;
					end
				endcase
			end
			S_SINK: begin
				case (step_q)
					3'd0: begin
						add_a   = hole_x_q;
						add_b   = pos_x_q;
						add_sub = 1'b1;
					end
					3'd1: begin
						add_a   = hole_y_q;
						add_b   = pos_y_q;
						add_sub = 1'b1;
						mul_a   = vel_x_q;
					end
					3'd2: begin
						add_a = pos_x_q;
						mul_a = vel_y_q;
					end
					default: begin
						add_a = pos_y_q;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	assign load_res = (state_q == S_DONE) && (!res_valid_q || result.ready);

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (load_res) begin
			res_q.position_x  <= pos_x_q;
			res_q.position_y  <= pos_y_q;
			res_q.velocity_x  <= vel_x_q;
			res_q.velocity_y  <= vel_y_q;
			res_q.radius_out  <= radius_q;
			res_q.sink_status <= status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= TIME_STEP_RST;
			drag_q      <= DRAG_RST;
			tolerance_q <= TOLERANCE_RST;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_TIME_STEP: time_step_q <= cfg.data.value[FW-1:0];
				REG_DRAG:      drag_q      <= cfg.data.value[FW-1:0];
				REG_TOLERANCE: tolerance_q <= cfg.data.value;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			res_valid_q <= 1'b0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			vel_x_q     <= '0;
			vel_y_q     <= '0;
			force_x_q   <= '0;
			force_y_q   <= '0;
			hole_x_q    <= '0;
			hole_y_q    <= Q_ONE;
			radius_q    <= '0;
			status_q    <= ST_TABLE;
		end else begin
			// The output register fills as the sequencer finishes and empties
			// when the waiting result is taken.
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					step_q <= '0;
					if (item.valid) begin
						case (item.data.mode)
							MODE_TICK: begin
								if (status_q == ST_TABLE) begin
									state_q <= S_TABLE;
								end else if (status_q == ST_SINKING) begin
									state_q <= S_SINK;
								end else begin
									state_q <= S_DONE;
								end
							end
							MODE_FORCE: begin
								state_q   <= S_DONE;
								force_x_q <= force_x_next;
								force_y_q <= force_y_next;
							end
							MODE_SINK: begin
								state_q  <= S_DONE;
								status_q <= ST_SINKING;
								hole_x_q <= item.data.value_x;
								hole_y_q <= item.data.value_y;
							end
							default: begin
								state_q   <= S_DONE;
								pos_x_q   <= item.data.value_x;
								pos_y_q   <= item.data.value_y;
								vel_x_q   <= '0;
								vel_y_q   <= '0;
								force_x_q <= '0;
								force_y_q <= '0;
								hole_x_q  <= '0;
								hole_y_q  <= Q_ONE;
								radius_q  <= item.data.radius_in;
								status_q  <= ST_TABLE;
							end
						endcase
					end
				end
				S_TABLE: begin
					step_q <= step_q + 3'd1;
					case (step_q)
						3'd1: vel_x_q <= sum;
						3'd2: vel_y_q <= sum;
						3'd3: pos_x_q <= sum;
						3'd4: pos_y_q <= sum;
						3'd5: vel_x_q <= below_tol ? '0 : sum;
						3'd6: vel_y_q <= below_tol ? '0 : sum;
						default: begin
						end
					endcase
					if (step_q == TABLE_LAST) begin
						force_x_q <= '0;
						force_y_q <= '0;
						state_q   <= S_DONE;
					end
				end
				S_SINK: begin
					step_q <= step_q + 3'd1;
					case (step_q)
						3'd0: vel_x_q <= sum;
						3'd1: vel_y_q <= sum;
						3'd2: pos_x_q <= sum;
						default: begin
							pos_y_q <= sum;
							if (radius_q != '0) begin
								radius_q <= radius_q - RADW'(1);
							end
							if ((mag(vel_x_q) < Q_FIVE) && (mag(vel_y_q) < Q_FIVE)) begin
								status_q <= ST_SUNK;
							end
						end
					endcase
					if (step_q == SINK_LAST) begin
						state_q <= S_DONE;
					end
				end
				default: begin
					if (load_res) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign item.ready   = (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;
	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule

// ----- hdl/bems_checker.sv -----
// Port-level assertions for the ball motion step block and their bind.
`timescale 1ns / 1ps
`include "ball_euler_motion_step_assert.svh"

module bems_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input bems_pkg::out_item_t out_data
);
	import bems_pkg::*;

	// The one status code that no request can produce.
	localparam logic [1:0] ST_UNUSED = 2'd3;

	// A waiting result keeps its value until it is taken.
	`BEMS_ASSERT(a_result_holds, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")

	// A request occupies the sequencer: no second request in the next cycle.
	`BEMS_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "request taken while busy")

	// A new result appears only as the sequencer returns to idle.
	`BEMS_ASSERT(a_result_at_idle, $rose(out_valid) |-> in_ready, "result raised while busy")

	// The unused status code never leaves the block.
	`BEMS_ASSERT(a_status_code, out_valid |-> out_data.sink_status != ST_UNUSED, "bad sink status")

endmodule

bind ball_euler_motion_step bems_checker u_bems_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);

// ----- bench/ball_euler_motion_step_tb.sv -----
// Self-checking testbench of the ball motion step block: directed rows, then random episodes.
`timescale 1ns / 1ps

module ball_euler_motion_step_tb;
	import bems_pkg::*;

	// Codes and limits local to the bench. The block ignores a write to the
	// fourth register index, so that index is exercised as well.
	localparam logic [1:0] REG_UNUSED  = 2'd3;
	localparam q_t         Q_MAX       = 24'sh7FFFFF;
	localparam q_t         Q_MIN       = 24'sh800000;
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         SEGMENTS    = 10;
	localparam int         SEG_ITEMS   = 125;

	// One directed row: the request, and the result typed in by hand when it
	// can be read straight off the request sequence.
	typedef struct packed {
		in_item_t  req;
		bit        typed;
		out_item_t want;
	} opening_row_t;

	logic clk = 1'b0;
	logic arst_n;

	bems_item_if   item_ch ();
	bems_result_if res_ch ();
	bems_cfg_if    cfg_ch ();

	ball_euler_motion_step i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// Shadow copy of the ball and of the three configuration registers. All of
	// it is updated at the clock edge on which the block accepts a request or
	// a register write, so it holds what the block holds once the request is done.
	longint     ball_px, ball_py, ball_vx, ball_vy;
	longint     push_fx, push_fy, hole_px, hole_py;
	int         ball_radius;
	logic [1:0] ball_status;
	longint     step_q, drag_q, stop_speed;

	out_item_t  expected_states[$];
	int         failures = 0;
	int         cycle_count = 0;
	int         items_sent = 0;
	int         sender_idle_pct = 0;
	int         receiver_stall_pct = 0;
	bit         cur_typed = 1'b0;
	out_item_t  cur_want = '0;

	// Clamp to the signed Q16.8 range.
	function automatic longint clamp_q(input longint v);
		if (v < longint'(Q_MIN)) return longint'(Q_MIN);
		if (v > longint'(Q_MAX)) return longint'(Q_MAX);
		return v;
	endfunction

	// Q16.8 value times an unsigned Q0.16 factor. Adding one half and taking
	// the arithmetic shift is the floor, so ties round toward plus infinity.
	function automatic longint scale_q(input longint a, input longint f);
		return clamp_q((a * f + 32768) >>> 16);
	endfunction

	function automatic longint abs_q(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Applies one request to the shadow ball and returns the state after it.
	function automatic out_item_t advance_ball(input in_item_t req);
		longint    in_x;
		longint    in_y;
		out_item_t st;
		in_x = longint'($signed(req.value_x));
		in_y = longint'($signed(req.value_y));
		case (req.mode)
			MODE_TICK: begin
				if (ball_status == ST_TABLE) begin
					// Explicit Euler: velocity first, then position from the new
					// velocity, then drag and the dead band around zero.
					ball_vx = clamp_q(ball_vx + scale_q(push_fx, step_q));
					ball_vy = clamp_q(ball_vy + scale_q(push_fy, step_q));
					ball_px = clamp_q(ball_px + scale_q(ball_vx, step_q));
					ball_py = clamp_q(ball_py + scale_q(ball_vy, step_q));
					ball_vx = scale_q(ball_vx, drag_q);
					ball_vy = scale_q(ball_vy, drag_q);
					if (abs_q(ball_vx) < stop_speed) ball_vx = 0;
					if (abs_q(ball_vy) < stop_speed) ball_vy = 0;
					push_fx = 0;
					push_fy = 0;
				end else if (ball_status == ST_SINKING) begin
					// The ball is pulled toward the hole; the force is kept.
					ball_vx = clamp_q(hole_px - ball_px);
					ball_vy = clamp_q(hole_py - ball_py);
					ball_px = clamp_q(ball_px + scale_q(ball_vx, step_q));
					ball_py = clamp_q(ball_py + scale_q(ball_vy, step_q));
					if (ball_radius > 0) ball_radius--;
					if (abs_q(ball_vx) < longint'(Q_FIVE) && abs_q(ball_vy) < longint'(Q_FIVE))
						ball_status = ST_SUNK;
				end
			end
			MODE_FORCE: begin
				push_fx = clamp_q(push_fx + in_x);
				push_fy = clamp_q(push_fy + in_y);
			end
			MODE_SINK: begin
				ball_status = ST_SINKING;
				hole_px     = in_x;
				hole_py     = in_y;
			end
			default: begin
				ball_px     = in_x;
				ball_py     = in_y;
				ball_vx     = 0;
				ball_vy     = 0;
				push_fx     = 0;
				push_fy     = 0;
				hole_px     = 0;
				hole_py     = longint'(Q_ONE);
				ball_radius = int'(req.radius_in);
				ball_status = ST_TABLE;
			end
		endcase
		st.position_x  = q_t'(ball_px);
		st.position_y  = q_t'(ball_py);
		st.velocity_x  = q_t'(ball_vx);
		st.velocity_y  = q_t'(ball_vy);
		st.radius_out  = ball_radius[RADW-1:0];
		st.sink_status = ball_status;
		return st;
	endfunction

	// A random Q16.8 value, leaning toward the range ends and toward small and
	// medium magnitudes so that saturation and the dead band both get hit.
	function automatic q_t pick_q();
		case ($urandom_range(0, 9))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return 24'sd0;
			3: return ($urandom_range(0, 1) != 0) ? 24'sd1 : -24'sd1;
			4, 5: return q_t'(longint'($urandom_range(0, 4096)) - 2048);
			6, 7: return q_t'(longint'($urandom_range(0, 131072)) - 65536);
			default: return q_t'($urandom());
		endcase
	endfunction

	// A point near a given coordinate. The closest band lands within 5.0 of
	// it, so a ball sent there from its own position sinks on the next tick.
	function automatic q_t near_q(input longint base);
		longint off;
		case ($urandom_range(0, 3))
			0: off = longint'($urandom_range(0, 2558)) - 1279;
			1, 2: off = longint'($urandom_range(0, 12000)) - 6000;
			default: off = longint'($urandom_range(0, 120000)) - 60000;
		endcase
		return q_t'(clamp_q(base + off));
	endfunction

	// Offers one request, starting and ending at a falling edge. The valid
	// line is left high on return so that back-to-back requests never see a
	// low and a high assigned in the same time step; callers lower it once.
	task automatic send_item(input logic [1:0] mode, input q_t vx, input q_t vy,
			input logic [RADW-1:0] rad);
		while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.data  <= '{mode, vx, vy, rad};
		item_ch.valid <= 1'b1;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// Register write, same convention as send_item.
	task automatic write_reg(input logic [1:0] idx, input logic [TOLW-1:0] val);
		cfg_ch.data  <= '{idx, val};
		cfg_ch.valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Stops offering requests and waits until every result is back.
	task automatic drain_requests();
		item_ch.valid <= 1'b0;
		@(negedge clk);
		while (expected_states.size() != 0) @(negedge clk);
	endtask

	task automatic report_field(input string field, input longint want, input longint got);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
	endtask

	// Watchdog: the slowest legal run stays far below this many cycles.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// The receiver stalls at random when the current phase asks for it.
	always @(negedge clk) begin
		res_ch.ready <= (receiver_stall_pct == 0) ||
			($urandom_range(0, 99) >= receiver_stall_pct);
	end

	// Everything is sampled at the rising edge. A returning result is matched
	// before a new request is predicted, since the block cannot answer a
	// request in the cycle that accepts it.
	always @(posedge clk) begin : watch_ports
		out_item_t got;
		out_item_t want;
		out_item_t predicted;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.data.index)
					REG_TIME_STEP: step_q     = longint'(cfg_ch.data.value[FW-1:0]);
					REG_DRAG:      drag_q     = longint'(cfg_ch.data.value[FW-1:0]);
					REG_TOLERANCE: stop_speed = longint'(cfg_ch.data.value);
					default: ;
				endcase
			end
			if (res_ch.valid && res_ch.ready) begin
				got = res_ch.data;
				if (expected_states.size() == 0) begin
					$display("%0t: result with nothing expected, actual %h", $time, got);
					failures++;
				end else begin
					want = expected_states.pop_front();
					if (got !== want) begin
						failures++;
						if (got.position_x !== want.position_x)
							report_field("position_x", want.position_x, got.position_x);
						if (got.position_y !== want.position_y)
							report_field("position_y", want.position_y, got.position_y);
						if (got.velocity_x !== want.velocity_x)
							report_field("velocity_x", want.velocity_x, got.velocity_x);
						if (got.velocity_y !== want.velocity_y)
							report_field("velocity_y", want.velocity_y, got.velocity_y);
						if (got.radius_out !== want.radius_out)
							report_field("radius_out", want.radius_out, got.radius_out);
						if (got.sink_status !== want.sink_status)
							report_field("sink_status", want.sink_status, got.sink_status);
					end
				end
			end
			if (item_ch.valid && item_ch.ready) begin
				// The shadow ball always advances; a hand-typed row only
				// replaces what is expected of that one result.
				predicted = advance_ball(item_ch.data);
				expected_states.push_back(cur_typed ? cur_want : predicted);
			end
		end
	end

	initial begin : run_stimulus
		opening_row_t opening_rows[$];
		int           seg;
		int           seg_start;
		int           n;
		logic [TOLW-1:0] ts_val;
		logic [TOLW-1:0] drag_val;
		logic [TOLW-1:0] tol_val;

		// Every input is known from time zero, while reset is held low.
		arst_n        = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.data  = '0;
		res_ch.ready  = 1'b0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.data   = '0;

		// Shadow state after reset.
		step_q      = longint'(TIME_STEP_RST);
		drag_q      = longint'(DRAG_RST);
		stop_speed  = longint'(TOLERANCE_RST);
		ball_px     = 0;
		ball_py     = 0;
		ball_vx     = 0;
		ball_vy     = 0;
		push_fx     = 0;
		push_fy     = 0;
		hole_px     = 0;
		hole_py     = longint'(Q_ONE);
		ball_radius = 0;
		ball_status = ST_TABLE;

		// Directed rows, run with the reset configuration. They cover a tick
		// straight after reset, placement at the range ends, saturating force
		// sums, a sinking ball with the hole at the far corner, sinking from a
		// radius of one down to zero and staying there, force and sink
		// requests on a sunk ball, and a plain place-push-tick-sink run.
		opening_rows = '{
			'{'{MODE_TICK, 24'sd0, 24'sd0, 8'd0}, 1'b1,
				'{24'sd0, 24'sd0, 24'sd0, 24'sd0, 8'd0, ST_TABLE}},
			'{'{MODE_PLACE, Q_MAX, Q_MIN, 8'd255}, 1'b1,
				'{Q_MAX, Q_MIN, 24'sd0, 24'sd0, 8'd255, ST_TABLE}},
			'{'{MODE_FORCE, Q_MAX, Q_MIN, 8'd0}, 1'b1,
				'{Q_MAX, Q_MIN, 24'sd0, 24'sd0, 8'd255, ST_TABLE}},
			'{'{MODE_FORCE, Q_MAX, Q_MIN, 8'd17}, 1'b1,
				'{Q_MAX, Q_MIN, 24'sd0, 24'sd0, 8'd255, ST_TABLE}},
			'{'{MODE_TICK, Q_MIN, Q_MAX, 8'd255}, 1'b0, '0},
			'{'{MODE_TICK, 24'sd0, 24'sd0, 8'd0}, 1'b0, '0},
			'{'{MODE_SINK, Q_MIN, Q_MAX, 8'd0}, 1'b0, '0},
			'{'{MODE_TICK, 24'sd0, 24'sd0, 8'd0}, 1'b0, '0},
			'{'{MODE_FORCE, 24'sd1, -24'sd1, 8'd0}, 1'b0, '0},
			'{'{MODE_TICK, 24'sd0, 24'sd0, 8'd0}, 1'b0, '0},
			'{'{MODE_PLACE, 24'sd0, 24'sd0, 8'd1}, 1'b1,
				'{24'sd0, 24'sd0, 24'sd0, 24'sd0, 8'd1, ST_TABLE}},
			'{'{MODE_SINK, 24'sd0, 24'sd0, 8'd0}, 1'b1,
				'{24'sd0, 24'sd0, 24'sd0, 24'sd0, 8'd1, ST_SINKING}},
			'{'{MODE_TICK, 24'sd0, 24'sd0, 8'd0}, 1'b1,
				'{24'sd0, 24'sd0, 24'sd0, 24'sd0, 8'd0, ST_SUNK}},
			'{'{MODE_TICK, 24'sd0, 24'sd0, 8'd0}, 1'b1,
				'{24'sd0, 24'sd0, 24'sd0, 24'sd0, 8'd0, ST_SUNK}},
			'{'{MODE_FORCE, 24'sd256, -24'sd256, 8'd0}, 1'b1,
				'{24'sd0, 24'sd0, 24'sd0, 24'sd0, 8'd0, ST_SUNK}},
			'{'{MODE_SINK, 24'sd256, 24'sd256, 8'd0}, 1'b1,
				'{24'sd0, 24'sd0, 24'sd0, 24'sd0, 8'd0, ST_SINKING}},
			'{'{MODE_TICK, 24'sd0, 24'sd0, 8'd0}, 1'b0, '0},
			'{'{MODE_PLACE, -24'sd1, 24'sd1, 8'd0}, 1'b1,
				'{-24'sd1, 24'sd1, 24'sd0, 24'sd0, 8'd0, ST_TABLE}},
			'{'{MODE_FORCE, Q_MIN, Q_MAX, 8'd0}, 1'b1,
				'{-24'sd1, 24'sd1, 24'sd0, 24'sd0, 8'd0, ST_TABLE}},
			'{'{MODE_TICK, 24'sd0, 24'sd0, 8'd0}, 1'b0, '0},
			'{'{MODE_TICK, 24'sd0, 24'sd0, 8'd0}, 1'b0, '0},
			'{'{MODE_PLACE, 24'sd25600, -24'sd25600, 8'd200}, 1'b1,
				'{24'sd25600, -24'sd25600, 24'sd0, 24'sd0, 8'd200, ST_TABLE}},
			'{'{MODE_FORCE, 24'sd15360, -24'sd15360, 8'd0}, 1'b0, '0},
			'{'{MODE_TICK, 24'sd0, 24'sd0, 8'd0}, 1'b0, '0},
			'{'{MODE_SINK, 24'sd26000, -24'sd25000, 8'd0}, 1'b0, '0}
		};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (opening_rows[i]) begin
			cur_typed = opening_rows[i].typed;
			cur_want  = opening_rows[i].want;
			send_item(opening_rows[i].req.mode, opening_rows[i].req.value_x,
				opening_rows[i].req.value_y, opening_rows[i].req.radius_in);
		end
		cur_typed = 1'b0;

		// Random part. Each segment starts from an idle block, rewrites all
		// registers (the first segment with the reset values, then the range ends,
		// then half-scale factors, then random settings) and runs under one idling pattern.
		for (seg = 0; seg < SEGMENTS; seg++) begin
			drain_requests();
			case (seg)
				0: begin
					ts_val   = TOLW'(TIME_STEP_RST);
					drag_val = TOLW'(DRAG_RST);
					tol_val  = TOLERANCE_RST;
				end
				1: begin
					// Upper bits above the 16-bit factors must be dropped.
					ts_val   = '1;
					drag_val = '1;
					tol_val  = '0;
				end
				2: begin
					ts_val   = '0;
					drag_val = '0;
					tol_val  = '1;
				end
				3: begin
					ts_val   = 23'd32768;
					drag_val = 23'd32768;
					tol_val  = 23'd1;
				end
				default: begin
					ts_val   = TOLW'($urandom());
					drag_val = ($urandom_range(0, 3) != 0) ?
						TOLW'($urandom_range(52000, 65535)) : TOLW'($urandom());
					tol_val  = ($urandom_range(0, 3) != 0) ?
						TOLW'($urandom_range(0, 3000)) : TOLW'($urandom());
				end
			endcase
			write_reg(REG_TIME_STEP, ts_val);
			write_reg(REG_DRAG, drag_val);
			write_reg(REG_TOLERANCE, tol_val);
			write_reg(REG_UNUSED, TOLW'($urandom()));
			cfg_ch.valid <= 1'b0;

			case (seg % 4)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 51; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 51; end
				default: begin sender_idle_pct = 33; receiver_stall_pct = 33; end
			endcase

			seg_start = items_sent;
			while (items_sent - seg_start < SEG_ITEMS) begin
				if ($urandom_range(0, 99) < 85) begin
					// A well-formed episode: place, push, roll, then usually
					// send the ball toward a hole close to where it stopped.
					send_item(MODE_PLACE, pick_q(), pick_q(), 8'($urandom_range(0, 255)));
					n = $urandom_range(0, 3);
					repeat (n) send_item(MODE_FORCE, pick_q(), pick_q(), 8'($urandom()));
					n = $urandom_range(1, 5);
					repeat (n) send_item(MODE_TICK, pick_q(), pick_q(), 8'($urandom()));
					if ($urandom_range(0, 99) < 70)
						send_item(MODE_SINK, near_q(ball_px), near_q(ball_py), 8'($urandom()));
					else
						send_item(MODE_SINK, pick_q(), pick_q(), 8'($urandom()));
					n = $urandom_range(1, 10);
					repeat (n) begin
						// A force now and then while sinking is kept for later.
						if ($urandom_range(0, 9) == 0)
							send_item(MODE_FORCE, pick_q(), pick_q(), 8'($urandom()));
						send_item(MODE_TICK, pick_q(), pick_q(), 8'($urandom()));
					end
				end else begin
					// Noise: any request in any order.
					n = $urandom_range(1, 6);
					repeat (n) send_item(2'($urandom()), pick_q(), pick_q(), 8'($urandom()));
				end
			end
		end

		drain_requests();
		repeat (20) @(posedge clk);
		if (expected_states.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_states.size());
			failures++;
		end
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
